FILE: design/bism_pkg.sv
// ----------------------------------------------------------------------------
// bism_pkg
// Shared sizes, filter coefficients, register indexes and the command and
// status types that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bism_pkg;

    // block geometry
    localparam int BLOCK_W = 64;
    localparam int BLOCK_H = 64;
    localparam int NPIX    = BLOCK_W * BLOCK_H;
    localparam int NLINES  = BLOCK_W + BLOCK_H;
    localparam int MAXDIM  = (BLOCK_W > BLOCK_H) ? BLOCK_W : BLOCK_H;

    localparam int ADDR_W  = $clog2(NPIX);
    localparam int X_W     = $clog2(MAXDIM);
    localparam int LI_W    = $clog2(MAXDIM + 128);
    localparam int NL_W    = $clog2(NLINES);
    localparam int NLC_W   = $clog2(NLINES + 1);

    // datapath widths
    localparam int PIX_W   = 16;
    localparam int ST_W    = 32;
    localparam int TSUM_W  = 48;
    localparam int OUT_W   = 32;
    localparam int SUM_W   = OUT_W + NLC_W;
    localparam int SQ_W    = 48 + NLC_W;
    localparam int NUM_W   = SQ_W;
    localparam int DEN_W   = 32;
    localparam int STEP_W  = $clog2(NUM_W + 1);
    localparam int RATIO_STEPS = 24;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd2;
    localparam int STRIDE_W = 7;
    localparam logic [15:0]         MIN_BAND_RST = 16'd7864;
    localparam logic [15:0]         GAIN_RST     = 16'd3840;
    localparam logic [STRIDE_W-1:0] STRIDE_RST   = 7'd1;

    // Q28 filter coefficients
    localparam logic signed [31:0] BP_B0 = 32'sd778463;
    localparam logic signed [31:0] BP_B1 = 32'sd2335388;
    localparam logic signed [31:0] BP_A1 = 32'sd637292616;
    localparam logic signed [31:0] BP_A2 = -32'sd517919369;
    localparam logic signed [31:0] BP_A3 = 32'sd142834506;
    localparam logic signed [31:0] HP_G0 = 32'sd8470843;
    localparam logic signed [31:0] HP_G1 = 32'sd25412529;
    localparam logic signed [31:0] HP_A1 = -32'sd391655132;
    localparam logic signed [31:0] HP_A2 = -32'sd244375318;
    localparam logic signed [31:0] HP_A3 = -32'sd53103294;

    // multiply-accumulate steps of one filter sample
    localparam logic [2:0] MAC_X0    = 3'd0;
    localparam logic [2:0] MAC_X1    = 3'd1;
    localparam logic [2:0] MAC_Y1    = 3'd2;
    localparam logic [2:0] MAC_Y2    = 3'd3;
    localparam logic [2:0] MAC_Y3    = 3'd4;
    localparam logic [2:0] MAC_TERMS = 3'd5;

    typedef enum logic [1:0] {
        DIV_RATIO = 2'd0,
        DIV_MEAN  = 2'd1,
        DIV_VAR   = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic       load;
        logic       blk_start;
        logic       line_start;
        logic       rd;
        logic [2:0] mac_k;
        logic       mac_mul;
        logic       mac_acc;
        logic       rnd;
        logic       ratio_sat;
        logic       div_start;
        t_div_sel   div_sel;
        logic       sq;
        logic       trap1;
        logic       trap2;
        logic       next;
        logic       lv1;
        logic       lv2;
        logic       lv3;
        logic       mean_take;
        logic       vrd;
        logic       vmul;
        logic       vacc;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_pixel;
        logic last_sample;
        logic last_line;
        logic last_entry;
        logic skip;
        logic sat;
        logic div_busy;
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: design/bism_div.sv
// ----------------------------------------------------------------------------
// bism_div
// Restoring divider, one quotient bit per cycle. The caller may preload a
// partial remainder and give the number of dividend bits to shift in.
// ----------------------------------------------------------------------------
module bism_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bism_pkg::DEN_W-1:0]   i_rem,
    input  logic [bism_pkg::NUM_W-1:0]   i_num,
    input  logic [bism_pkg::DEN_W-1:0]   i_den,
    input  logic [bism_pkg::STEP_W-1:0]  i_steps,
    output logic                         o_busy,
    output logic [bism_pkg::NUM_W-1:0]   o_quo
);

    logic                         r_busy;
    logic [bism_pkg::STEP_W-1:0]  r_cnt;
    logic [bism_pkg::DEN_W-1:0]   r_rem;
    logic [bism_pkg::NUM_W-1:0]   r_num;
    logic [bism_pkg::DEN_W-1:0]   r_den;
    logic [bism_pkg::NUM_W-1:0]   r_quo;

    logic [bism_pkg::DEN_W:0]     rem2;
    logic [bism_pkg::DEN_W:0]     rdiff;
    logic                         ge;

    assign rem2  = {r_rem, r_num[bism_pkg::NUM_W-1]};
    assign ge    = rem2 >= {1'b0, r_den};
    assign rdiff = rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == bism_pkg::STEP_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= i_steps;
            r_rem <= i_rem;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - bism_pkg::STEP_W'(1);
            r_rem <= ge ? rdiff[bism_pkg::DEN_W-1:0] : rem2[bism_pkg::DEN_W-1:0];
            r_num <= {r_num[bism_pkg::NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[bism_pkg::NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

FILE: design/bism_dp.sv
// ----------------------------------------------------------------------------
// bism_dp
// Datapath: pixel store, shared filter multipliers, ratio and statistics
// division, trapezoid integration, line store and the output register.
// ----------------------------------------------------------------------------
module bism_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bism_pkg::t_dp_cmd                 i_cmd,
    output bism_pkg::t_dp_stat                o_stat,
    input  logic [bism_pkg::PIX_W-1:0]        i_pixel,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [bism_pkg::OUT_W-1:0]        o_block_sharpness,
    output logic [bism_pkg::OUT_W-1:0]        o_sharpness_variance,
    input  logic                              i_cfg_we,
    input  logic [bism_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bism_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [bism_pkg::OUT_W-1:0]  OUT_MAX  = '1;
    localparam logic [bism_pkg::TSUM_W-1:0] TSUM_MAX = '1;

    // configuration
    logic [15:0]                     r_min_band;
    logic [15:0]                     r_gain;
    logic [bism_pkg::STRIDE_W-1:0]   r_stride;

    // stores
    logic [bism_pkg::PIX_W-1:0]  pixel_mem [bism_pkg::NPIX];
    logic [bism_pkg::OUT_W-1:0]  line_mem  [bism_pkg::NLINES];

    logic [bism_pkg::ADDR_W-1:0] r_pcnt;
    logic [bism_pkg::ADDR_W-1:0] r_addr;
    logic [bism_pkg::PIX_W-1:0]  r_pix;

    // line walk
    logic                        r_dir;
    logic [bism_pkg::LI_W-1:0]   r_li;
    logic [bism_pkg::X_W-1:0]    r_x;
    logic [bism_pkg::NLC_W-1:0]  r_n;
    logic [bism_pkg::NLC_W-1:0]  r_j;

    // filter state
    logic [bism_pkg::PIX_W-1:0]        r_ih [3];
    logic signed [bism_pkg::ST_W-1:0]  r_bh [3];
    logic signed [bism_pkg::ST_W-1:0]  r_hh [3];
    logic signed [63:0]                r_bprod;
    logic signed [63:0]                r_hprod;
    logic signed [63:0]                r_bacc;
    logic signed [63:0]                r_hacc;
    logic signed [bism_pkg::ST_W-1:0]  r_bp;
    logic signed [bism_pkg::ST_W-1:0]  r_hp;

    // integration
    logic [31:0]                       r_r;
    logic [bism_pkg::X_W+32:0]         r_tprod;
    logic [bism_pkg::TSUM_W-1:0]       r_tsum;
    logic [31:0]                       r_pratio;
    logic [bism_pkg::X_W-1:0]          r_ppos;
    logic                              r_pvalid;
    logic [39:0]                       r_phi;
    logic [39:0]                       r_plo;

    // statistics
    logic [bism_pkg::SUM_W-1:0]  r_sum;
    logic [bism_pkg::SQ_W-1:0]   r_sq;
    logic [bism_pkg::OUT_W-1:0]  r_mean;
    logic [bism_pkg::OUT_W-1:0]  r_lrd;
    logic [63:0]                 r_dsq;
    logic                        r_ovalid;
    logic [bism_pkg::OUT_W-1:0]  r_osharp;
    logic [bism_pkg::OUT_W-1:0]  r_ovar;

    // combinational
    logic [bism_pkg::STRIDE_W-1:0]      stride;
    logic [bism_pkg::LI_W-1:0]          li_next;
    logic [bism_pkg::X_W-1:0]           len_m1;
    logic [bism_pkg::ADDR_W-1:0]        line_base;
    logic [bism_pkg::ADDR_W-1:0]        addr_step;
    logic signed [31:0]                 bcoef;
    logic signed [31:0]                 hcoef;
    logic signed [32:0]                 bop;
    logic signed [32:0]                 hop;
    logic signed [64:0]                 bprod_full;
    logic signed [64:0]                 hprod_full;
    logic [bism_pkg::PIX_W:0]           psum0;
    logic [bism_pkg::PIX_W:0]           psum1;
    logic signed [bism_pkg::PIX_W:0]    pdif0;
    logic signed [bism_pkg::PIX_W:0]    pdif1;
    logic signed [bism_pkg::ST_W-1:0]   bp_new;
    logic signed [bism_pkg::ST_W-1:0]   hp_new;
    logic [31:0]                        mag;
    logic signed [bism_pkg::ST_W-1:0]   level;
    logic [23:0]                        q24;
    logic [47:0]                        qsq;
    logic [bism_pkg::X_W-1:0]           dx;
    logic [32:0]                        rsum;
    logic [bism_pkg::X_W+32:0]          tprod_full;
    logic [bism_pkg::TSUM_W:0]          tsum_add;
    logic [39:0]                        phi_full;
    logic [39:0]                        plo_full;
    logic [63:0]                        lv_total;
    logic [bism_pkg::OUT_W-1:0]         lv;
    logic [bism_pkg::OUT_W-1:0]         dabs;
    logic [63:0]                        dsq_full;
    logic [bism_pkg::DEN_W-1:0]         div_rem;
    logic [bism_pkg::NUM_W-1:0]         div_num;
    logic [bism_pkg::DEN_W-1:0]         div_den;
    logic [bism_pkg::STEP_W-1:0]        div_steps;
    logic                               div_busy;
    logic [bism_pkg::NUM_W-1:0]         div_quo;

    function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] a);
        logic signed [63:0] t;
        logic signed [35:0] v;
        t = a + 64'sd134217728;
        v = $signed(t[63:28]);
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
            return v[31:0];
        end else if (v[35]) begin
            return 32'sh80000000;
        end else begin
            return 32'sh7FFFFFFF;
        end
    endfunction

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_band <= bism_pkg::MIN_BAND_RST;
            r_gain     <= bism_pkg::GAIN_RST;
            r_stride   <= bism_pkg::STRIDE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bism_pkg::CFG_MIN_BAND: r_min_band <= i_cfg_data;
                bism_pkg::CFG_GAIN:     r_gain     <= i_cfg_data;
                bism_pkg::CFG_STRIDE:   r_stride   <= i_cfg_data[bism_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ pixel store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            pixel_mem[r_pcnt] <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_pix <= pixel_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= '0;
        end else if (i_cmd.load) begin
            if (r_pcnt == bism_pkg::ADDR_W'(bism_pkg::NPIX - 1)) begin
                r_pcnt <= '0;
            end else begin
                r_pcnt <= r_pcnt + bism_pkg::ADDR_W'(1);
            end
        end
    end

    // -------------------------------------------------------------- line walk
    assign stride    = (r_stride == '0) ? bism_pkg::STRIDE_W'(1) : r_stride;
    assign li_next   = r_li + bism_pkg::LI_W'(stride);
    assign len_m1    = r_dir ? bism_pkg::X_W'(bism_pkg::BLOCK_W - 1)
                             : bism_pkg::X_W'(bism_pkg::BLOCK_H - 1);
    assign line_base = r_dir ? bism_pkg::ADDR_W'(r_li * bism_pkg::BLOCK_W)
                             : bism_pkg::ADDR_W'(r_li);
    assign addr_step = r_dir ? bism_pkg::ADDR_W'(1) : bism_pkg::ADDR_W'(bism_pkg::BLOCK_W);

    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_start) begin
            r_dir <= 1'b0;
            r_li  <= '0;
            r_n   <= '0;
            r_sum <= '0;
        end else if (i_cmd.lv3) begin
            r_n   <= r_n + bism_pkg::NLC_W'(1);
            r_sum <= r_sum + bism_pkg::SUM_W'(lv);
            if (!r_dir && li_next >= bism_pkg::LI_W'(bism_pkg::BLOCK_W)) begin
                r_dir <= 1'b1;
                r_li  <= '0;
            end else begin
                r_li  <= li_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.line_start) begin
            r_x    <= '0;
            r_addr <= line_base;
        end else if (i_cmd.next) begin
            r_x    <= r_x + bism_pkg::X_W'(1);
            r_addr <= r_addr + addr_step;
        end
    end

    // ---------------------------------------------------------------- filters
    assign psum0 = {1'b0, r_pix} + {1'b0, r_ih[2]};
    assign psum1 = {1'b0, r_ih[0]} + {1'b0, r_ih[1]};
    assign pdif0 = $signed({1'b0, r_pix}) - $signed({1'b0, r_ih[2]});
    assign pdif1 = $signed({1'b0, r_ih[1]}) - $signed({1'b0, r_ih[0]});

    always_comb begin
        bcoef = '0;
        hcoef = '0;
        bop   = '0;
        hop   = '0;
        case (i_cmd.mac_k)
            bism_pkg::MAC_X0: begin
                bcoef = bism_pkg::BP_B0;
                hcoef = bism_pkg::HP_G0;
                bop   = $signed({4'b0000, psum0, 12'h000});
                hop   = $signed({{4{pdif0[bism_pkg::PIX_W]}}, pdif0, 12'h000});
            end
            bism_pkg::MAC_X1: begin
                bcoef = bism_pkg::BP_B1;
                hcoef = bism_pkg::HP_G1;
                bop   = $signed({4'b0000, psum1, 12'h000});
                hop   = $signed({{4{pdif1[bism_pkg::PIX_W]}}, pdif1, 12'h000});
            end
            bism_pkg::MAC_Y1: begin
                bcoef = bism_pkg::BP_A1;
                hcoef = bism_pkg::HP_A1;
                bop   = {r_bh[0][31], r_bh[0]};
                hop   = {r_hh[0][31], r_hh[0]};
            end
            bism_pkg::MAC_Y2: begin
                bcoef = bism_pkg::BP_A2;
                hcoef = bism_pkg::HP_A2;
                bop   = {r_bh[1][31], r_bh[1]};
                hop   = {r_hh[1][31], r_hh[1]};
            end
            bism_pkg::MAC_Y3: begin
                bcoef = bism_pkg::BP_A3;
                hcoef = bism_pkg::HP_A3;
                bop   = {r_bh[2][31], r_bh[2]};
                hop   = {r_hh[2][31], r_hh[2]};
            end
            default: ;
        endcase
    end

    assign bprod_full = bcoef * bop;
    assign hprod_full = hcoef * hop;
    assign bp_new     = rnd_sat(r_bacc);
    assign hp_new     = rnd_sat(r_hacc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_mul) begin
            r_bprod <= bprod_full[63:0];
            r_hprod <= hprod_full[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_bacc <= '0;
            r_hacc <= '0;
        end else if (i_cmd.mac_acc) begin
            r_bacc <= r_bacc + r_bprod;
            r_hacc <= r_hacc + r_hprod;
        end
    end

    // shift the histories on every sample, used or skipped
    always_ff @(posedge i_clk) begin
        if (i_cmd.line_start) begin
            for (int i = 0; i < 3; i++) begin
                r_ih[i] <= '0;
                r_bh[i] <= '0;
                r_hh[i] <= '0;
            end
        end else if (i_cmd.rnd) begin
            r_ih[2] <= r_ih[1];
            r_ih[1] <= r_ih[0];
            r_ih[0] <= r_pix;
            r_bh[2] <= r_bh[1];
            r_bh[1] <= r_bh[0];
            r_bh[0] <= bp_new;
            r_hh[2] <= r_hh[1];
            r_hh[1] <= r_hh[0];
            r_hh[0] <= hp_new;
            r_bp    <= bp_new;
            r_hp    <= hp_new;
        end
    end

    // ------------------------------------------------------------ ratio
    assign mag   = r_hp[31] ? 32'(-r_hp) : 32'(r_hp);
    assign level = $signed({4'b0000, r_min_band, 12'h000});
    assign q24   = div_quo[23:0];
    assign qsq   = q24 * q24;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ratio_sat) begin
            r_r <= '1;
        end else if (i_cmd.sq) begin
            r_r <= qsq[47:16];
        end
    end

    // --------------------------------------------------------- trapezoid
    assign dx         = r_x - r_ppos;
    assign rsum       = {1'b0, r_r} + {1'b0, r_pratio};
    assign tprod_full = dx * rsum;
    assign tsum_add   = {1'b0, r_tsum} + (bism_pkg::TSUM_W + 1)'(r_tprod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.trap1) begin
            r_tprod <= tprod_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.line_start) begin
            r_tsum   <= '0;
            r_pratio <= '0;
            r_ppos   <= '0;
            r_pvalid <= 1'b0;
        end else if (i_cmd.trap2) begin
            if (r_pvalid) begin
                r_tsum <= tsum_add[bism_pkg::TSUM_W] ? TSUM_MAX
                                                    : tsum_add[bism_pkg::TSUM_W-1:0];
            end
            r_pratio <= r_r;
            r_ppos   <= r_x;
            r_pvalid <= 1'b1;
        end
    end

    // ------------------------------------------------------------ line value
    assign phi_full = r_tsum[47:24] * r_gain;
    assign plo_full = r_tsum[23:0] * r_gain;
    assign lv_total = {r_phi, 24'h000000} + 64'(r_plo);
    assign lv       = (lv_total[63:41] != '0) ? OUT_MAX : lv_total[40:9];

    always_ff @(posedge i_clk) begin
        if (i_cmd.lv1) begin
            r_phi <= phi_full;
        end
        if (i_cmd.lv2) begin
            r_plo <= plo_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lv3) begin
            line_mem[r_n[bism_pkg::NL_W-1:0]] <= lv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vrd) begin
            r_lrd <= line_mem[r_j[bism_pkg::NL_W-1:0]];
        end
    end

    // ------------------------------------------------------------ statistics
    assign dabs     = (r_lrd >= r_mean) ? r_lrd - r_mean : r_mean - r_lrd;
    assign dsq_full = dabs * dabs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_take) begin
            r_mean <= div_quo[bism_pkg::OUT_W-1:0];
            r_sq   <= '0;
            r_j    <= '0;
        end else if (i_cmd.vacc) begin
            r_sq   <= r_sq + bism_pkg::SQ_W'(r_dsq[63:16]);
            r_j    <= r_j + bism_pkg::NLC_W'(1);
        end
        if (i_cmd.vmul) begin
            r_dsq <= dsq_full;
        end
    end

    // --------------------------------------------------------------- divider
    always_comb begin
        div_rem   = '0;
        div_num   = '0;
        div_den   = '0;
        div_steps = bism_pkg::STEP_W'(bism_pkg::NUM_W);
        case (i_cmd.div_sel)
            bism_pkg::DIV_RATIO: begin
                div_rem   = bism_pkg::DEN_W'(mag[31:8]);
                div_num   = {mag[7:0], 16'h0000, {(bism_pkg::NUM_W - 24){1'b0}}};
                div_den   = r_bp;
                div_steps = bism_pkg::STEP_W'(bism_pkg::RATIO_STEPS);
            end
            bism_pkg::DIV_MEAN: begin
                div_num = bism_pkg::NUM_W'(r_sum);
                div_den = bism_pkg::DEN_W'(r_n);
            end
            bism_pkg::DIV_VAR: begin
                div_num = bism_pkg::NUM_W'(r_sq);
                div_den = bism_pkg::DEN_W'(r_n - bism_pkg::NLC_W'(1));
            end
            default: ;
        endcase
    end

    bism_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_rem   (div_rem),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // ----------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_osharp <= r_mean;
            r_ovar   <= (div_quo[bism_pkg::NUM_W-1:bism_pkg::OUT_W] != '0)
                        ? OUT_MAX : div_quo[bism_pkg::OUT_W-1:0];
        end
    end

    assign o_valid              = r_ovalid;
    assign o_block_sharpness    = r_osharp;
    assign o_sharpness_variance = r_ovar;

    // ----------------------------------------------------------------- status
    always_comb begin
        o_stat.last_pixel  = r_pcnt == bism_pkg::ADDR_W'(bism_pkg::NPIX - 1);
        o_stat.last_sample = r_x == len_m1;
        o_stat.last_line   = r_dir && li_next >= bism_pkg::LI_W'(bism_pkg::BLOCK_H);
        o_stat.last_entry  = r_j == (r_n - bism_pkg::NLC_W'(1));
        o_stat.skip        = r_bp < level;
        o_stat.sat         = (r_bp == '0) || ({8'h00, mag[31:8]} >= 32'(r_bp));
        o_stat.div_busy    = div_busy;
        o_stat.out_busy    = r_ovalid && i_stall;
    end

endmodule

FILE: design/bism_ctrl.sv
// ----------------------------------------------------------------------------
// bism_ctrl
// Sequencer: pixel loading, per-sample filter and ratio steps, per-line
// scaling, then mean and variance over the stored line values.
// ----------------------------------------------------------------------------
module bism_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  bism_pkg::t_dp_stat    i_stat,
    output bism_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [21:0] {
        S_LOAD   = 22'h000001,
        S_LSTART = 22'h000002,
        S_RD     = 22'h000004,
        S_MAC    = 22'h000008,
        S_RND    = 22'h000010,
        S_CHK    = 22'h000020,
        S_DIV    = 22'h000040,
        S_SQ     = 22'h000080,
        S_TRAP1  = 22'h000100,
        S_TRAP2  = 22'h000200,
        S_NEXT   = 22'h000400,
        S_LV1    = 22'h000800,
        S_LV2    = 22'h001000,
        S_LV3    = 22'h002000,
        S_MEAN   = 22'h004000,
        S_MEANW  = 22'h008000,
        S_VRD    = 22'h010000,
        S_VMUL   = 22'h020000,
        S_VACC   = 22'h040000,
        S_VDIV   = 22'h080000,
        S_VDIVW  = 22'h100000,
        S_OUT    = 22'h200000
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [2:0]  r_k;
    logic [2:0]  n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        o_cmd         = '0;
        o_cmd.div_sel = bism_pkg::DIV_RATIO;
        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.last_pixel) begin
                        o_cmd.blk_start = 1'b1;
                        n_state         = S_LSTART;
                    end
                end
            end
            S_LSTART: begin
                o_cmd.line_start = 1'b1;
                n_state          = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_k      = bism_pkg::MAC_X0;
                n_state  = S_MAC;
            end
            S_MAC: begin
                // product of step k is registered, then added in the next step
                o_cmd.mac_k   = r_k;
                o_cmd.mac_mul = r_k != bism_pkg::MAC_TERMS;
                o_cmd.mac_acc = r_k != bism_pkg::MAC_X0;
                if (r_k == bism_pkg::MAC_TERMS) begin
                    n_state = S_RND;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                if (i_stat.skip) begin
                    n_state = S_NEXT;
                end else if (i_stat.sat) begin
                    o_cmd.ratio_sat = 1'b1;
                    n_state         = S_TRAP1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_TRAP1;
            end
            S_TRAP1: begin
                o_cmd.trap1 = 1'b1;
                n_state     = S_TRAP2;
            end
            S_TRAP2: begin
                o_cmd.trap2 = 1'b1;
                n_state     = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                n_state    = i_stat.last_sample ? S_LV1 : S_RD;
            end
            S_LV1: begin
                o_cmd.lv1 = 1'b1;
                n_state   = S_LV2;
            end
            S_LV2: begin
                o_cmd.lv2 = 1'b1;
                n_state   = S_LV3;
            end
            S_LV3: begin
                o_cmd.lv3 = 1'b1;
                n_state   = i_stat.last_line ? S_MEAN : S_LSTART;
            end
            S_MEAN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bism_pkg::DIV_MEAN;
                n_state         = S_MEANW;
            end
            S_MEANW: begin
                if (!i_stat.div_busy) begin
                    o_cmd.mean_take = 1'b1;
                    n_state         = S_VRD;
                end
            end
            S_VRD: begin
                o_cmd.vrd = 1'b1;
                n_state   = S_VMUL;
            end
            S_VMUL: begin
                o_cmd.vmul = 1'b1;
                n_state    = S_VACC;
            end
            S_VACC: begin
                o_cmd.vacc = 1'b1;
                n_state    = i_stat.last_entry ? S_VDIV : S_VRD;
            end
            S_VDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = bism_pkg::DIV_VAR;
                n_state         = S_VDIVW;
            end
            S_VDIVW: begin
                o_cmd.div_sel = bism_pkg::DIV_VAR;
                if (!i_stat.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the previous result has been taken
                o_cmd.div_sel = bism_pkg::DIV_VAR;
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_stall = r_state != S_LOAD;

endmodule

FILE: design/block_iir_sharpness_metric.sv
// ----------------------------------------------------------------------------
// block_iir_sharpness_metric
// Loads a block one pixel per cycle while i_valid is high, then filters each
// sample and forms its ratio (24-step divider) unless skipped or saturated,
// scales each line and divides for mean and variance. The result register
// is loaded once the variance division is done and the previous result is
// taken; loading of the next block resumes as soon as it is loaded. The
// synchronous active-low reset clears state, pixel count, busy and valid.
// ----------------------------------------------------------------------------
module block_iir_sharpness_metric (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bism_pkg::PIX_W-1:0]        i_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bism_pkg::OUT_W-1:0]        o_block_sharpness,
    output logic [bism_pkg::OUT_W-1:0]        o_sharpness_variance,
    input  logic                              i_cfg_we,
    input  logic [bism_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bism_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    bism_pkg::t_dp_cmd   cmd;
    bism_pkg::t_dp_stat  stat;

    bism_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bism_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_pixel              (i_pixel),
        .i_stall              (i_stall),
        .o_valid              (o_valid),
        .o_block_sharpness    (o_block_sharpness),
        .o_sharpness_variance (o_sharpness_variance),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data)
    );

endmodule
